### src/sli_pkg.sv
// Shared types and constants for the sorted list insert/search unit.
package sli_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int IDX_W        = 4;
  localparam int CNT_OUT_W    = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2
  } sli_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } sli_status_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } sli_in_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_OUT_W-1:0]    count;
    logic [1:0]              status;
  } sli_out_t;

endpackage

### src/sli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sli_ctrl.sv
// Command sequencer: walks the entry RAM to insert, search and read.
module sli_ctrl #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  sli_pkg::sli_in_t            req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output sli_pkg::sli_out_t           res_o,
  output logic                        mem_we_o,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr_o,
  output logic [sli_pkg::VAL_W-1:0]   mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr_o,
  input  logic [sli_pkg::VAL_W-1:0]   mem_rdata_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS0,
    S_SRCH,
    S_RD,
    S_DONE
  } state_e;

  state_e                          state_q, state_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [AW-1:0]                   ptr_q, ptr_d;
  logic signed [sli_pkg::VAL_W-1:0] val_q, val_d;
  logic                            found_q, found_d;
  logic [sli_pkg::VAL_W-1:0]       entry_q, entry_d;
  logic [1:0]                      status_q, status_d;

  logic signed [sli_pkg::VAL_W-1:0] rd_val;
  logic [31:0]                      idx_ext;
  logic [31:0]                      cnt_ext;

  assign rd_val  = $signed(mem_rdata_i);
  assign idx_ext = 32'(req_i.index);
  assign cnt_ext = 32'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    val_d       = val_q;
    found_d     = found_q;
    entry_d     = entry_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q + AW'(1);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          val_d    = req_i.value;
          found_d  = 1'b0;
          entry_d  = '0;
          status_d = sli_pkg::ST_OK;
          state_d  = S_DONE;
          unique case (req_i.cmd)
            sli_pkg::CMD_INSERT: begin
              if (cnt_ext >= 32'(CAPACITY)) begin
                status_d = sli_pkg::ST_FULL;
              end else if (cnt_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = req_i.value;
                cnt_d       = cnt_q + CW'(1);
              end else begin
                ptr_d       = AW'(cnt_q - CW'(1));
                mem_raddr_o = AW'(cnt_q - CW'(1));
                state_d     = S_INS;
              end
            end
            sli_pkg::CMD_SEARCH: begin
              if (cnt_q != '0) begin
                ptr_d       = '0;
                mem_raddr_o = '0;
                state_d     = S_SRCH;
              end
            end
            sli_pkg::CMD_READ: begin
              if (idx_ext < cnt_ext) begin
                mem_raddr_o = idx_ext[AW-1:0];
                state_d     = S_RD;
              end else begin
                status_d = sli_pkg::ST_BAD_INDEX;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q + AW'(1);
        if (rd_val >= val_q) begin
          // shift this entry up one place
          mem_wdata_o = mem_rdata_i;
          if (ptr_q == '0) begin
            state_d = S_INS0;
          end else begin
            ptr_d       = ptr_q - AW'(1);
            mem_raddr_o = ptr_q - AW'(1);
          end
        end else begin
          mem_wdata_o = val_q;
          cnt_d       = cnt_q + CW'(1);
          state_d     = S_DONE;
        end
      end
      S_INS0: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CW'(1);
        state_d     = S_DONE;
      end
      S_SRCH: begin
        if (rd_val == val_q) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (rd_val > val_q) begin
          state_d = S_DONE;
        end else if (CW'(ptr_q) + CW'(1) == cnt_q) begin
          state_d = S_DONE;
        end else begin
          ptr_d       = ptr_q + AW'(1);
          mem_raddr_o = ptr_q + AW'(1);
        end
      end
      S_RD: begin
        entry_d = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      val_q    <= '0;
      found_q  <= 1'b0;
      entry_q  <= '0;
      status_q <= sli_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      val_q    <= val_d;
      found_q  <= found_d;
      entry_q  <= entry_d;
      status_q <= status_d;
    end
  end

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.found       = found_q;
  assign res_o.entry_value = $signed(entry_q);
  assign res_o.count       = cnt_ext[sli_pkg::CNT_OUT_W-1:0];
  assign res_o.status      = status_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> 32'(mem_waddr_o) <= cnt_ext)
    else $error("write beyond the occupied range");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> cnt_ext == 32'($past(cnt_q)) + 32'd1)
    else $error("entry count moved by other than one");
`endif

endmodule

### src/sorted_list_insert_search_unit.sv
// Inserts and searches walk the entry RAM one word per cycle through its single read port.
// One command is in work at a time; the next is taken once the result is handed to the
// output register, which may still be waiting downstream.
// Reset clears the entry count and control; RAM contents are not cleared.
module sorted_list_insert_search_unit #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sli_pkg::sli_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sli_pkg::sli_out_t out_word_o
);

  localparam int AW = $clog2(CAPACITY);

  logic                      req_ready;
  logic                      res_valid;
  logic                      res_ready;
  sli_pkg::sli_out_t         res;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [sli_pkg::VAL_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [sli_pkg::VAL_W-1:0] mem_rdata;

  logic              out_valid_q;
  sli_pkg::sli_out_t out_word_q;

  sli_ram #(
    .WIDTH(sli_pkg::VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  sli_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(req_ready),
    .req_i      (in_word_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_word_q <= res;
    end
  end

  assign in_stall_o  = !req_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
